### rtl/cfbd_pkg.sv
// ----------------------------------------------------------------------------
// cfbd_pkg
// Shared types, codes and helpers for the CAN 2.0B frame bit decoder.
// ----------------------------------------------------------------------------
package cfbd_pkg;

	// Widths fixed by the item layout
	localparam int unsigned SAMPLE_BITS    = 48;
	localparam int unsigned MAX_PAYLOAD    = 8;
	localparam int unsigned SAMPLE_WIDTH   = 48;
	localparam int unsigned IN_TDATA_BITS  = 56;
	localparam int unsigned OUT_TDATA_BITS = 72;

	// CRC-15 generator
	localparam logic [14:0] CRC_POLY = 15'h4599;

	// Frame field sequencer states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_ID     = 4'd1,
		ST_EXT    = 4'd2,
		ST_CTRL   = 4'd3,
		ST_DATA   = 4'd4,
		ST_CRC    = 4'd5,
		ST_CRCDEL = 4'd6,
		ST_ACK    = 4'd7,
		ST_EOF    = 4'd8,
		ST_INTER  = 4'd9,
		ST_ERR    = 4'd10
	} field_state_t;

	// Per-bit mark codes
	localparam logic [3:0] MARK_NONE     = 4'd0;
	localparam logic [3:0] MARK_START    = 4'd1;
	localparam logic [3:0] MARK_FIELD    = 4'd2;
	localparam logic [3:0] MARK_STUFF    = 4'd3;
	localparam logic [3:0] MARK_ERR_X    = 4'd4;
	localparam logic [3:0] MARK_RTR_REC  = 4'd5;
	localparam logic [3:0] MARK_RTR_DOM  = 4'd6;
	localparam logic [3:0] MARK_ZERO     = 4'd7;
	localparam logic [3:0] MARK_ONE      = 4'd8;
	localparam logic [3:0] MARK_ACK      = 4'd9;
	localparam logic [3:0] MARK_ACK_MISS = 4'd10;
	localparam logic [3:0] MARK_ERR_BIT  = 4'd11;

	// Field event kinds
	localparam logic [3:0] EV_STD_ID  = 4'd0;
	localparam logic [3:0] EV_EXT_ID  = 4'd1;
	localparam logic [3:0] EV_CONTROL = 4'd2;
	localparam logic [3:0] EV_DATA    = 4'd3;
	localparam logic [3:0] EV_CRC     = 4'd4;
	localparam logic [3:0] EV_ACK     = 4'd5;
	localparam logic [3:0] EV_EOF     = 4'd6;
	localparam logic [3:0] EV_INTER   = 4'd7;
	localparam logic [3:0] EV_ERR_END = 4'd8;

	// Field lengths and thresholds
	localparam logic [6:0] STD_ID_BITS  = 7'd11;
	localparam logic [6:0] STD_RTR_POS  = 7'd12;
	localparam logic [6:0] EXT_ID_BITS  = 7'd18;
	localparam logic [6:0] EXT_RTR_POS  = 7'd19;
	localparam logic [6:0] CTRL_R0_POS  = 7'd2;
	localparam logic [6:0] CTRL_END_POS = 7'd6;
	localparam logic [6:0] CRC_BITS     = 7'd15;
	localparam logic [6:0] EOF_BITS     = 7'd7;
	localparam logic [6:0] INTER_BITS   = 7'd3;
	localparam logic [3:0] STUFF_LIMIT  = 4'd5;
	localparam logic [3:0] STUFF_ERR_RUN = 4'd6;
	localparam logic [3:0] ERR_END_RUN  = 4'd11;
	localparam logic [3:0] DLC_MAX      = 4'd8;
	localparam logic [7:0] STUFF_CNT_MAX = 8'd255;

	// One CRC-15 shift step
	function automatic logic [14:0] crc_step(input logic [14:0] crc, input logic b);
		logic [14:0] shifted;
		shifted = {crc[13:0], 1'b0};
		crc_step = (b ^ crc[14]) ? (shifted ^ CRC_POLY) : shifted;
	endfunction

endpackage

### rtl/can_frame_bit_decoder.sv
// Each bit passes the bit register, then the result register, before the master side.
// One bus bit per cycle while the master side takes results; the two registers run back
// to back. The field sequencer updates its state once per bit in the single pass between them.
// Reset (arst_n low, asynchronous) empties both stages and returns the sequencer to idle
// with all counters, CRC and identifier cleared. No clearing pass is needed.
// ----------------------------------------------------------------------------
// can_frame_bit_decoder
// Decodes CAN 2.0B frames one sampled bus bit at a time: destuffing, field
// sequencing, CRC-15 check and error recovery, one result per bit.
// ----------------------------------------------------------------------------
module can_frame_bit_decoder #(
	parameter int unsigned SAMPLE_WIDTH = cfbd_pkg::SAMPLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [0] bus_bit, [48:1] sample_index, [55:49] zero
	input  logic [cfbd_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [3:0] bit_mark, [4] event_valid, [8:5] event_kind, [56:9] event_value,
	// [71:57] event_aux
	output logic [cfbd_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

	// Effective width of the frame length arithmetic
	localparam int unsigned SWE = (SAMPLE_WIDTH < cfbd_pkg::SAMPLE_BITS) ?
		SAMPLE_WIDTH : cfbd_pkg::SAMPLE_BITS;

	// Input stage
	logic                                in_valid_s1;
	logic                                bus_bit_s1;
	logic [cfbd_pkg::SAMPLE_BITS-1:0]    sample_s1;
	logic                                advance;

	// Sequencer state
	cfbd_pkg::field_state_t state_q, state_d;
	logic          destuff_q, destuff_d;
	logic [3:0]    run_q, run_d;
	logic          last_q, last_d;
	logic [7:0]    stuffed_q, stuffed_d;
	logic [14:0]   crc_q, crc_d;
	logic [14:0]   crc_end_q, crc_end_d;
	logic [6:0]    bitpos_q, bitpos_d;
	logic [28:0]   frame_id_q, frame_id_d;
	logic          remote_q, remote_d;
	logic [3:0]    dlc_q, dlc_d;
	logic [7:0]    byte_q, byte_d;
	logic [SWE-1:0] start_q, start_d;

	// Per-bit result
	logic [3:0]    mark;
	logic          ev_valid;
	logic [3:0]    ev_kind;
	logic [47:0]   ev_value;
	logic [14:0]   ev_aux;
	logic          decode;
	logic          b;
	logic [2:0]    idx;
	logic [SWE-1:0] frame_len;

	// Result stage
	logic          out_valid_s2;
	logic [3:0]    mark_s2;
	logic          ev_valid_s2;
	logic [3:0]    ev_kind_s2;
	logic [47:0]   ev_value_s2;
	logic [14:0]   ev_aux_s2;

	// Move a bit to the result stage whenever that stage is free or draining
	assign advance       = in_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	// Hold the input valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	// Capture the input payload on each transfer
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			bus_bit_s1 <= s_axis_tdata[0];
			sample_s1  <= s_axis_tdata[cfbd_pkg::SAMPLE_BITS:1];
		end
	end

	assign b         = bus_bit_s1;
	assign idx       = bitpos_q[5:3];
	assign frame_len = sample_s1[SWE-1:0] - start_q;

	// Destuff, then run the field sequencer for one bit
	always_comb begin
		state_d    = state_q;
		destuff_d  = destuff_q;
		run_d      = run_q;
		last_d     = last_q;
		stuffed_d  = stuffed_q;
		crc_d      = crc_q;
		crc_end_d  = crc_end_q;
		bitpos_d   = bitpos_q;
		frame_id_d = frame_id_q;
		remote_d   = remote_q;
		dlc_d      = dlc_q;
		byte_d     = byte_q;
		start_d    = start_q;
		mark       = cfbd_pkg::MARK_NONE;
		ev_valid   = 1'b0;
		ev_kind    = '0;
		ev_value   = '0;
		ev_aux     = '0;
		decode     = 1'b0;

		// Stuff bit removal and run tracking
		if (!destuff_q) begin
			decode = 1'b1;
		end else if (run_q == cfbd_pkg::STUFF_LIMIT && b != last_q) begin
			mark   = cfbd_pkg::MARK_STUFF;
			run_d  = 4'd1;
			last_d = b;
			if (stuffed_q < cfbd_pkg::STUFF_CNT_MAX) begin
				stuffed_d = stuffed_q + 8'd1;
			end
		end else if (run_q == cfbd_pkg::STUFF_LIMIT) begin
			mark      = cfbd_pkg::MARK_ERR_X;
			state_d   = cfbd_pkg::ST_ERR;
			destuff_d = 1'b0;
			run_d     = cfbd_pkg::STUFF_ERR_RUN;
		end else if (b == last_q) begin
			run_d  = run_q + 4'd1;
			decode = 1'b1;
		end else begin
			run_d  = 4'd1;
			last_d = b;
			decode = 1'b1;
		end

		if (decode) begin
			case (state_q)
				cfbd_pkg::ST_ID: begin
					crc_d    = cfbd_pkg::crc_step(crc_q, b);
					bitpos_d = bitpos_q + 7'd1;
					if (bitpos_d <= cfbd_pkg::STD_ID_BITS) begin
						mark       = cfbd_pkg::MARK_FIELD;
						frame_id_d = {frame_id_q[27:0], b};
					end else if (bitpos_d == cfbd_pkg::STD_RTR_POS) begin
						mark     = b ? cfbd_pkg::MARK_RTR_REC : cfbd_pkg::MARK_RTR_DOM;
						remote_d = b;
					end else begin
						mark = cfbd_pkg::MARK_FIELD;
						if (b) begin
							state_d  = cfbd_pkg::ST_EXT;
							bitpos_d = '0;
						end else begin
							ev_valid = 1'b1;
							ev_kind  = cfbd_pkg::EV_STD_ID;
							ev_value = 48'(frame_id_q);
							ev_aux   = 15'(!remote_q);
							dlc_d    = '0;
							state_d  = cfbd_pkg::ST_CTRL;
							bitpos_d = 7'd1;
						end
					end
				end
				cfbd_pkg::ST_EXT: begin
					crc_d    = cfbd_pkg::crc_step(crc_q, b);
					bitpos_d = bitpos_q + 7'd1;
					if (bitpos_d <= cfbd_pkg::EXT_ID_BITS) begin
						mark       = cfbd_pkg::MARK_FIELD;
						frame_id_d = {frame_id_q[27:0], b};
					end else if (bitpos_d == cfbd_pkg::EXT_RTR_POS) begin
						mark     = b ? cfbd_pkg::MARK_RTR_REC : cfbd_pkg::MARK_RTR_DOM;
						remote_d = b;
					end else begin
						// r1: the id is reported even when r1 is recessive
						mark     = b ? cfbd_pkg::MARK_ERR_X : cfbd_pkg::MARK_ZERO;
						ev_valid = 1'b1;
						ev_kind  = cfbd_pkg::EV_EXT_ID;
						ev_value = 48'(frame_id_q);
						ev_aux   = 15'(!remote_q);
						if (b) begin
							state_d   = cfbd_pkg::ST_ERR;
							destuff_d = 1'b0;
						end else begin
							state_d  = cfbd_pkg::ST_CTRL;
							bitpos_d = 7'd1;
							dlc_d    = '0;
						end
					end
				end
				cfbd_pkg::ST_CTRL: begin
					crc_d    = cfbd_pkg::crc_step(crc_q, b);
					bitpos_d = bitpos_q + 7'd1;
					if (bitpos_d == cfbd_pkg::CTRL_R0_POS) begin
						mark = b ? cfbd_pkg::MARK_ERR_X : cfbd_pkg::MARK_ZERO;
						if (b) begin
							state_d   = cfbd_pkg::ST_ERR;
							destuff_d = 1'b0;
						end
					end else begin
						mark  = cfbd_pkg::MARK_FIELD;
						dlc_d = {dlc_q[2:0], b};
						if (bitpos_d >= cfbd_pkg::CTRL_END_POS) begin
							// Report the raw code, clamp it for byte counting
							ev_valid  = 1'b1;
							ev_kind   = cfbd_pkg::EV_CONTROL;
							ev_value  = 48'(dlc_d);
							bitpos_d  = '0;
							if (dlc_d > cfbd_pkg::DLC_MAX) begin
								dlc_d = cfbd_pkg::DLC_MAX;
							end
							crc_end_d = crc_d;
							state_d   = (dlc_d == '0 || remote_q) ?
								cfbd_pkg::ST_CRC : cfbd_pkg::ST_DATA;
						end
					end
				end
				cfbd_pkg::ST_DATA: begin
					crc_d    = cfbd_pkg::crc_step(crc_q, b);
					mark     = cfbd_pkg::MARK_FIELD;
					byte_d   = {byte_q[6:0], b};
					bitpos_d = bitpos_q + 7'd1;
					if (bitpos_d[2:0] == 3'd0) begin
						ev_valid = 1'b1;
						ev_kind  = cfbd_pkg::EV_DATA;
						ev_value = 48'(byte_d);
						ev_aux   = 15'(idx);
					end
					if (bitpos_d >= {dlc_q, 3'b000}) begin
						bitpos_d  = '0;
						state_d   = cfbd_pkg::ST_CRC;
						crc_end_d = crc_d;
					end
				end
				cfbd_pkg::ST_CRC: begin
					crc_d    = cfbd_pkg::crc_step(crc_q, b);
					mark     = cfbd_pkg::MARK_FIELD;
					bitpos_d = bitpos_q + 7'd1;
					if (bitpos_d >= cfbd_pkg::CRC_BITS) begin
						bitpos_d = '0;
						ev_valid = 1'b1;
						ev_kind  = cfbd_pkg::EV_CRC;
						ev_value = 48'(crc_end_q);
						ev_aux   = crc_d;
						if (crc_d != '0) begin
							state_d   = cfbd_pkg::ST_ERR;
							destuff_d = 1'b0;
						end else begin
							state_d = cfbd_pkg::ST_CRCDEL;
						end
					end
				end
				cfbd_pkg::ST_CRCDEL: begin
					destuff_d = 1'b0;
					if (b) begin
						mark    = cfbd_pkg::MARK_ONE;
						state_d = cfbd_pkg::ST_ACK;
					end else begin
						state_d = cfbd_pkg::ST_ERR;
						last_d  = b;
						run_d   = 4'd1;
					end
				end
				cfbd_pkg::ST_ACK: begin
					bitpos_d = bitpos_q + 7'd1;
					if (bitpos_d == 7'd1) begin
						mark = b ? cfbd_pkg::MARK_ACK_MISS : cfbd_pkg::MARK_ACK;
					end else begin
						ev_valid = 1'b1;
						ev_kind  = cfbd_pkg::EV_ACK;
						bitpos_d = '0;
						if (b) begin
							mark    = cfbd_pkg::MARK_ONE;
							state_d = cfbd_pkg::ST_EOF;
						end else begin
							state_d   = cfbd_pkg::ST_ERR;
							destuff_d = 1'b0;
							last_d    = b;
							run_d     = 4'd1;
						end
					end
				end
				cfbd_pkg::ST_EOF: begin
					if (!b) begin
						state_d   = cfbd_pkg::ST_ERR;
						destuff_d = 1'b0;
						last_d    = b;
						run_d     = 4'd1;
					end else begin
						mark     = cfbd_pkg::MARK_ONE;
						bitpos_d = bitpos_q + 7'd1;
						if (bitpos_d >= cfbd_pkg::EOF_BITS) begin
							ev_valid = 1'b1;
							ev_kind  = cfbd_pkg::EV_EOF;
							bitpos_d = '0;
							state_d  = cfbd_pkg::ST_INTER;
						end
					end
				end
				cfbd_pkg::ST_INTER: begin
					if (!b) begin
						state_d   = cfbd_pkg::ST_ERR;
						destuff_d = 1'b0;
						last_d    = b;
						run_d     = 4'd1;
					end else begin
						mark     = cfbd_pkg::MARK_ONE;
						bitpos_d = bitpos_q + 7'd1;
						if (bitpos_d >= cfbd_pkg::INTER_BITS) begin
							ev_valid = 1'b1;
							ev_kind  = cfbd_pkg::EV_INTER;
							ev_value = 48'(frame_len);
							ev_aux   = 15'(stuffed_q);
							bitpos_d = '0;
							state_d  = cfbd_pkg::ST_IDLE;
						end
					end
				end
				cfbd_pkg::ST_ERR: begin
					// Wait for eleven recessive bits in a row
					destuff_d = 1'b0;
					mark      = cfbd_pkg::MARK_ERR_BIT;
					if (last_d != b) begin
						run_d  = 4'd1;
						last_d = b;
					end else if (b) begin
						run_d = run_d + 4'd1;
						if (run_d == cfbd_pkg::ERR_END_RUN) begin
							ev_valid = 1'b1;
							ev_kind  = cfbd_pkg::EV_ERR_END;
							state_d  = cfbd_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					// Idle: a dominant bit is start of frame
					if (!b) begin
						destuff_d  = 1'b1;
						crc_d      = cfbd_pkg::crc_step('0, b);
						run_d      = 4'd1;
						last_d     = 1'b0;
						mark       = cfbd_pkg::MARK_START;
						bitpos_d   = '0;
						frame_id_d = '0;
						state_d    = cfbd_pkg::ST_ID;
						start_d    = sample_s1[SWE-1:0];
						stuffed_d  = '0;
					end else begin
						state_d = cfbd_pkg::ST_IDLE;
					end
				end
			endcase
		end
	end

	// Advance the sequencer state once per bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cfbd_pkg::ST_IDLE;
			destuff_q  <= 1'b0;
			run_q      <= '0;
			last_q     <= 1'b0;
			stuffed_q  <= '0;
			crc_q      <= '0;
			crc_end_q  <= '0;
			bitpos_q   <= '0;
			frame_id_q <= '0;
			remote_q   <= 1'b0;
			dlc_q      <= '0;
			start_q    <= '0;
		end else if (advance) begin
			state_q    <= state_d;
			destuff_q  <= destuff_d;
			run_q      <= run_d;
			last_q     <= last_d;
			stuffed_q  <= stuffed_d;
			crc_q      <= crc_d;
			crc_end_q  <= crc_end_d;
			bitpos_q   <= bitpos_d;
			frame_id_q <= frame_id_d;
			remote_q   <= remote_d;
			dlc_q      <= dlc_d;
			start_q    <= start_d;
		end
	end

	// Data byte shift register and result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q      <= byte_d;
			mark_s2     <= mark;
			ev_valid_s2 <= ev_valid;
			ev_kind_s2  <= ev_kind;
			ev_value_s2 <= ev_value;
			ev_aux_s2   <= ev_aux;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {ev_aux_s2, ev_value_s2, ev_kind_s2, ev_valid_s2, mark_s2};

`ifndef ASSERT_OFF
	// Destuffing is off whenever the sequencer is idle or recovering from an error
	a_idle_no_destuff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cfbd_pkg::ST_IDLE || state_q == cfbd_pkg::ST_ERR) |-> !destuff_q)
		else $error("destuffing active outside a frame");

	// Data bytes are only taken for data frames with a clamped length of one to eight
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cfbd_pkg::ST_DATA) |->
		(!remote_q && dlc_q != '0 && dlc_q <= cfbd_pkg::DLC_MAX))
		else $error("data field entered with bad length");

	// A result without an event carries zero event fields
	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !ev_valid_s2) |->
		(ev_kind_s2 == '0 && ev_value_s2 == '0 && ev_aux_s2 == '0))
		else $error("event fields set without an event");

	// A bit is moved on only while the result stage can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !m_axis_tready) |=> ($stable(mark_s2) && $stable(ev_value_s2)))
		else $error("pending result overwritten");
`endif

endmodule
